[sv/wildcard_byte_signature_scanner_defines.svh]
// Assertion macros for the wildcard byte signature scanner.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef WILDCARD_BYTE_SIGNATURE_SCANNER_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WBSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wbss check failed");

// Next-cycle implication, checked outside reset.
`define WBSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wbss check failed");

`endif

[sv/wbss_pkg.sv]
// Shared types and constants of the wildcard byte signature scanner.
// No dependencies; used by the cell, the result stage and the top level.
`default_nettype none

package wbss_pkg;

    localparam int BYTE_W       = 8;
    localparam int CFG_W        = 7;
    localparam int OUT_OFFSET_W = 32;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 32;

    // Input tdata layout, lowest bit up
    localparam int IDX_LSB  = 0;
    localparam int IDX_W    = 6;
    localparam int VAL_LSB  = 6;
    localparam int WILD_BIT = 14;
    localparam int BYTE_LSB = 15;

    // Input tuser codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    typedef struct packed {
        logic              wild;
        logic [BYTE_W-1:0] value;
    } t_sig_entry;

    typedef struct packed {
        logic       shift;
        logic       rot_next;
        logic       rot_prev;
        t_sig_entry ld_entry;
    } t_cell_ctrl;

    typedef struct packed {
        logic                    valid;
        logic                    eoi;
        logic                    guard;
        logic [OUT_OFFSET_W-1:0] offset;
    } t_scan_info;

endpackage

`default_nettype wire

[sv/wildcard_byte_signature_scanner.sv]
// Wildcard byte signature scanner, top level; uses wbss_pkg, wbss_cell, wbss_result.
// Throughput: one beat per cycle, loads and scans alike, while the output is taken
// and the ring is aligned. Scan results pass the hit registers, then the output register.
// A pattern_length write rotates the signature ring one cell per cycle while the input
// stalls, until it matches the new length. Reset is synchronous, active low,
// clears control state and sets pattern_length to 1; no clearing pass.
`default_nettype none
`include "wildcard_byte_signature_scanner_defines.svh"

module wildcard_byte_signature_scanner #(
    parameter int MAX_PATTERN = 64,
    parameter int OFFSET_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // fields, lowest bit up: pattern_index[5:0], pattern_value[13:6],
    // pattern_wild[14], data_byte[22:15], zero pad[23]
    input  logic [wbss_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // fields: opcode[0]
    input  logic [0:0]                         i_s_tuser,
    // end_of_image
    input  logic                               i_s_tlast,
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // fields: match_offset[31:0]
    output logic [wbss_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // fields: match_found[0]
    output logic [0:0]                         o_m_tuser,
    // pattern_length write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wbss_pkg::CFG_W-1:0]         i_cfg_data
);
    import wbss_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int SW = $clog2(2 * MAX_PATTERN);
    localparam int AW = LW + 1;
    localparam int CW = (OFFSET_BITS > LW) ? OFFSET_BITS : LW;

    // Organization: cell c holds window byte of age MAX_PATTERN-1-c (the newest
    // byte enters at the top cell and moves down one cell per scan beat) and
    // signature entry (c + len - MAX_PATTERN) mod MAX_PATTERN. With that
    // alignment, every active entry sits in the cell whose window byte it is
    // compared with; the active cells are the top len cells.
    // Changing len rotates the signature ring toward the new alignment, one
    // position per cycle, while the input is held off.

    logic [CFG_W-1:0]        r_cfg_len;
    logic [LW-1:0]           eff_len;
    logic [LW-1:0]           r_align;
    logic                    aligned;
    logic                    rot_next;
    logic                    rot_prev;

    logic                    opcode;
    logic [IDX_W-1:0]        ld_idx;
    logic [BYTE_W-1:0]       ld_value;
    logic                    ld_wild;
    logic [BYTE_W-1:0]       scan_byte;
    logic                    eoi;

    logic                    accept;
    logic                    scan_fire;
    logic                    load_fire;
    logic                    idx_ok;
    logic [SW-1:0]           ld_sum;
    logic [SW-1:0]           ld_cell;

    logic [OFFSET_BITS-1:0]  r_seen;
    logic [OFFSET_BITS-1:0]  n_seen;
    logic [CW-1:0]           seen_ext;
    logic [CW-1:0]           len_ext;
    logic [CW-1:0]           diff;

    t_scan_info              r_s1;
    logic                    w_take;
    t_cell_ctrl              w_ctrl;
    logic [MAX_PATTERN-1:0]  w_ld_sel;
    logic [MAX_PATTERN-1:0]  w_active;
    logic [MAX_PATTERN-1:0]  w_hits;
    logic [BYTE_W-1:0]       w_win [MAX_PATTERN];
    t_sig_entry              w_sig [MAX_PATTERN];

    // Clamp pattern_length: zero acts as one, above the depth acts as the depth
    always_comb begin
        if (r_cfg_len == '0) begin
            eff_len = LW'(1);
        end else if (int'(r_cfg_len) > MAX_PATTERN) begin
            eff_len = LW'(MAX_PATTERN);
        end else begin
            eff_len = LW'(r_cfg_len);
        end
    end

    assign aligned     = (r_align == eff_len);
    assign rot_next    = !aligned && (eff_len > r_align);
    assign rot_prev    = !aligned && (eff_len < r_align);
    assign o_cfg_ready = aligned;

    // Unpack the input beat
    assign opcode    = i_s_tuser[0];
    assign ld_idx    = i_s_tdata[IDX_LSB +: IDX_W];
    assign ld_value  = i_s_tdata[VAL_LSB +: BYTE_W];
    assign ld_wild   = i_s_tdata[WILD_BIT];
    assign scan_byte = i_s_tdata[BYTE_LSB +: BYTE_W];
    assign eoi       = i_s_tlast;

    // Take a beat while the ring is aligned and stage one is free or drains this cycle
    assign o_s_tready = aligned && (!r_s1.valid || w_take);
    assign accept     = i_s_tvalid && o_s_tready;
    assign scan_fire  = accept && (opcode == OP_SCAN);

    // Map a load index onto its ring cell; ignore indexes beyond the depth
    assign idx_ok    = (int'(ld_idx) < MAX_PATTERN);
    assign load_fire = accept && (opcode == OP_LOAD) && idx_ok;
    assign ld_sum    = SW'(ld_idx) + SW'(MAX_PATTERN) - SW'(r_align);
    assign ld_cell   = (ld_sum >= SW'(MAX_PATTERN)) ? (ld_sum - SW'(MAX_PATTERN)) : ld_sum;

    // Byte counter saturates; the offset comes from the count after this byte
    assign n_seen   = (&r_seen) ? r_seen : (r_seen + OFFSET_BITS'(1));
    assign seen_ext = CW'(n_seen);
    assign len_ext  = CW'(eff_len);
    assign diff     = seen_ext - len_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= CFG_W'(1);
            r_align   <= LW'(1);
            r_seen    <= '0;
            r_s1      <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_len <= i_cfg_data;
            end
            if (rot_next) begin
                r_align <= r_align + LW'(1);
            end else if (rot_prev) begin
                r_align <= r_align - LW'(1);
            end
            // The final byte always closes the image
            if (scan_fire) begin
                r_seen <= eoi ? '0 : n_seen;
            end
            if (accept) begin
                r_s1.valid <= scan_fire;
            end else if (w_take) begin
                r_s1.valid <= 1'b0;
            end
            if (scan_fire) begin
                r_s1.eoi    <= eoi;
                r_s1.guard  <= (seen_ext >= len_ext);
                r_s1.offset <= OUT_OFFSET_W'(diff);
            end
        end
    end

    // Broadcast controls for the cell row
    assign w_ctrl.shift          = scan_fire;
    assign w_ctrl.rot_next       = rot_next;
    assign w_ctrl.rot_prev       = rot_prev;
    assign w_ctrl.ld_entry.wild  = ld_wild;
    assign w_ctrl.ld_entry.value = ld_value;

    for (genvar c = 0; c < MAX_PATTERN; c++) begin : g_cell
        localparam logic [AW-1:0] CELL_POS = AW'(c);
        localparam int            UP       = (c + 1) % MAX_PATTERN;
        localparam int            DOWN     = (c + MAX_PATTERN - 1) % MAX_PATTERN;

        logic [BYTE_W-1:0] win_in;

        assign w_ld_sel[c] = load_fire && (ld_cell == SW'(c));
        assign w_active[c] = (CELL_POS + AW'(eff_len)) >= AW'(MAX_PATTERN);

        // the top cell takes the new byte; the others take the cell above
        if (c == MAX_PATTERN - 1) begin : g_top
            assign win_in = scan_byte;
        end else begin : g_mid
            assign win_in = w_win[c + 1];
        end

        wbss_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_ld       (w_ld_sel[c]),
            .i_active   (w_active[c]),
            .i_win_in   (win_in),
            .o_win      (w_win[c]),
            .i_sig_next (w_sig[UP]),
            .i_sig_prev (w_sig[DOWN]),
            .o_sig      (w_sig[c]),
            .o_hit      (w_hits[c])
        );
    end

    wbss_result #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_info     (r_s1),
        .i_hits     (w_hits),
        .o_take     (w_take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // A realignment step moves the ring every cycle until it lands
    `WBSS_ASSERT_NEXT(a_realign_moves, r_align != eff_len, r_align != $past(r_align))
    // No load may write the ring while it is being rotated
    `WBSS_ASSERT_NOW(a_no_load_in_rotate, !aligned, w_ld_sel == '0)
    // A scan held in stage one stays there while the output beat is stalled
    `WBSS_ASSERT_NEXT(a_s1_holds, r_s1.valid && o_m_tvalid && !i_m_tready, r_s1.valid)

endmodule

`default_nettype wire

[sv/wbss_cell.sv]
// One compare cell: a window byte, a signature entry and a registered hit.
// Depends on wbss_pkg.
`default_nettype none

module wbss_cell (
    input  logic                          i_clk,
    input  wbss_pkg::t_cell_ctrl          i_ctrl,
    input  logic                          i_ld,
    input  logic                          i_active,
    input  logic [wbss_pkg::BYTE_W-1:0]   i_win_in,
    output logic [wbss_pkg::BYTE_W-1:0]   o_win,
    input  wbss_pkg::t_sig_entry          i_sig_next,
    input  wbss_pkg::t_sig_entry          i_sig_prev,
    output wbss_pkg::t_sig_entry          o_sig,
    output logic                          o_hit
);
    import wbss_pkg::*;

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] n_win;
    t_sig_entry        r_sig;
    t_sig_entry        n_sig;
    logic              r_hit;
    logic              n_hit;

    always_comb begin
        n_win = i_ctrl.shift ? i_win_in : r_win;
        // compare the incoming window byte against the current entry
        n_hit = i_ctrl.shift ? (!i_active || r_sig.wild || (r_sig.value == i_win_in)) : r_hit;
        if (i_ld) begin
            n_sig = i_ctrl.ld_entry;
        end else if (i_ctrl.rot_next) begin
            n_sig = i_sig_next;
        end else if (i_ctrl.rot_prev) begin
            n_sig = i_sig_prev;
        end else begin
            n_sig = r_sig;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        r_sig <= n_sig;
        r_hit <= n_hit;
    end

    assign o_win = r_win;
    assign o_sig = r_sig;
    assign o_hit = r_hit;

endmodule

`default_nettype wire

[sv/wbss_result.sv]
// Result stage: reduce cell hits, track the reported flag, hold the output beat.
// Depends on wbss_pkg.
`default_nettype none

module wbss_result #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wbss_pkg::t_scan_info                i_info,
    input  logic [MAX_PATTERN-1:0]              i_hits,
    output logic                                o_take,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [wbss_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic [0:0]                          o_m_tuser
);
    import wbss_pkg::*;

    logic                    r_valid;
    logic                    r_reported;
    logic                    r_found;
    logic [OUT_OFFSET_W-1:0] r_offset;
    logic                    n_emit;
    logic                    n_reported;
    logic                    n_found;
    logic [OUT_OFFSET_W-1:0] n_offset;
    logic                    found;

    assign found  = (&i_hits) && i_info.guard;
    assign o_take = i_info.valid && (!r_valid || i_m_tready);

    always_comb begin
        n_emit     = 1'b0;
        n_reported = r_reported;
        n_found    = 1'b0;
        n_offset   = '0;
        if (r_reported) begin
            // drop bytes until the image closes
            if (i_info.eoi) begin
                n_reported = 1'b0;
            end
        end else if (found) begin
            n_emit     = 1'b1;
            n_found    = 1'b1;
            n_offset   = i_info.offset;
            n_reported = !i_info.eoi;
        end else if (i_info.eoi) begin
            n_emit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_reported <= 1'b0;
        end else if (o_take) begin
            r_valid    <= n_emit;
            r_reported <= n_reported;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && n_emit) begin
            r_found  <= n_found;
            r_offset <= n_offset;
        end
    end

    assign o_m_tvalid   = r_valid;
    assign o_m_tdata    = OUT_TDATA_W'(r_offset);
    assign o_m_tuser[0] = r_found;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the wildcard byte signature scanner: a scoreboard
// class predicts the found / not-found reports, plain tasks drive load and scan
// beats. Depends only on wbss_pkg and the scanner RTL.

module tb;
    import wbss_pkg::*;

    typedef struct {
        bit        found;
        bit [31:0] offset;
    } match_report_t;

    // Tracks signature, window and image progress, and holds the reports
    // that the scanner owes us, oldest first.
    class match_tracker;
        logic [7:0]    sig_value [64];
        bit            sig_wild  [64];
        logic [7:0]    window    [64];
        bit [31:0]     byte_count;
        bit            reported;
        bit [6:0]      length_reg;
        match_report_t expected_reports [$];
        int            errors;

        function new();
            foreach (sig_value[i]) begin
                sig_value[i] = 8'h00;
                sig_wild[i]  = 1'b0;
            end
            length_reg = 7'd1;
            errors     = 0;
            close_image();
        endfunction

        function void close_image();
            foreach (window[i]) window[i] = 8'h00;
            byte_count = '0;
            reported   = 1'b0;
        endfunction

        function void set_length(bit [6:0] length_val);
            length_reg = length_val;
        endfunction

        // Zero acts as one, anything past the ring acts as the full ring.
        function int active_length();
            if (length_reg == 0)
                return 1;
            if (length_reg > 64)
                return 64;
            return length_reg;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void absorb_beat(logic op, bit [5:0] idx, bit [7:0] value, bit wild,
                                  bit [7:0] data, bit eoi);
            int            k;
            int            eff;
            bit            hit;
            match_report_t report;
            if (op == OP_LOAD) begin
                sig_value[idx] = value;
                sig_wild[idx]  = wild;
                return;
            end
            // After a hit, bytes only wait for the end of the image.
            if (reported) begin
                if (eoi)
                    close_image();
                return;
            end
            for (k = 63; k > 0; k--)
                window[k] = window[k-1];
            window[0] = data;
            if (byte_count != 32'hFFFF_FFFF)
                byte_count++;
            eff = active_length();
            hit = (byte_count >= eff);
            for (k = 0; k < eff; k++)
                if (!sig_wild[k] && sig_value[k] != window[eff-1-k])
                    hit = 1'b0;
            if (hit) begin
                report.found  = 1'b1;
                report.offset = byte_count - 32'(eff);
                expected_reports.push_back(report);
                reported = 1'b1;
                if (eoi)
                    close_image();
            end else if (eoi) begin
                report.found  = 1'b0;
                report.offset = '0;
                expected_reports.push_back(report);
                close_image();
            end
        endfunction

        function void check_report(bit found, bit [31:0] offset);
            match_report_t exp_report;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got found=%0d offset=%0d",
                         $time, found, offset);
                errors++;
                return;
            end
            exp_report = expected_reports.pop_front();
            if (found !== exp_report.found) begin
                $display("%0t: match_found mismatch, expected %0d, got %0d",
                         $time, exp_report.found, found);
                errors++;
            end
            if (offset !== exp_report.offset) begin
                $display("%0t: match_offset mismatch, expected %0d, got %0d",
                         $time, exp_report.offset, offset);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [0:0]             i_s_tuser;
    logic                   i_s_tlast;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [0:0]             o_m_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;

    match_tracker tracker;

    // Copy of what has been loaded, used to plant signatures into images.
    logic [7:0] loaded_value [64];
    bit         loaded_wild  [64];

    int beats_sent    = 0;
    bit in_gaps_on    = 1'b1;
    bit out_stalls_on = 1'b1;
    bit hold_off_req  = 1'b0;

    wildcard_byte_signature_scanner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling: far above the slowest legal run of this stimulus.
    initial begin
        #5_000_000;
        $display("Run timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one beat, with an optional idle burst first; hold it until taken,
    // then hand it to the tracker. Inputs move only on the falling edge.
    task automatic send_beat(input logic op, input bit [5:0] idx, input bit [7:0] value,
                             input bit wild, input bit [7:0] data, input bit eoi);
        logic [IN_TDATA_W-1:0] fields;
        fields                      = '0;
        fields[IDX_LSB +: IDX_W]    = idx;
        fields[VAL_LSB +: BYTE_W]   = value;
        fields[WILD_BIT]            = wild;
        fields[BYTE_LSB +: BYTE_W]  = data;
        @(negedge i_clk);
        if (in_gaps_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_tdata  = fields;
        i_s_tuser  = op;
        i_s_tlast  = eoi;
        i_s_tvalid = 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        tracker.absorb_beat(op, idx, value, wild, data, eoi);
        if (op == OP_LOAD) begin
            loaded_value[idx] = value;
            loaded_wild[idx]  = wild;
        end
        beats_sent++;
    endtask

    // Scan beat; the load fields carry noise that the scanner must ignore.
    task automatic send_scan(input bit [7:0] data, input bit eoi);
        send_beat(OP_SCAN, 6'($urandom), 8'($urandom), 1'($urandom), data, eoi);
    endtask

    // Write pattern_length only once the scanner is drained: drop the stream,
    // wait for the owed reports, then let the pipeline settle.
    task automatic write_pattern_length(input bit [6:0] length_val);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_data  = length_val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tracker.set_length(length_val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One image of random bytes; most images carry the current signature at a
    // random spot, sometimes running past the end so that it must not count.
    // A stray load now and then rewrites an entry mid-image.
    task automatic scan_image(input int eff, input bit short_image);
        logic [7:0] img [$];
        int         n;
        int         spot;
        int         j;
        n = short_image ? $urandom_range(1, 3) : $urandom_range(1, 2 * eff + 12);
        repeat (n) img.push_back(8'($urandom));
        if ($urandom_range(0, 9) < 6) begin
            spot = $urandom_range(0, n - 1);
            for (j = 0; j < eff && spot + j < n; j++)
                img[spot + j] = loaded_wild[j] ? 8'($urandom) : loaded_value[j];
        end
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 24) == 0)
                send_beat(OP_LOAD, 6'($urandom), 8'($urandom), 1'($urandom),
                          8'($urandom), 1'($urandom));
            send_scan(img[j], j == n - 1);
        end
    endtask

    // Set the length, reload every active entry, then stream images until the
    // beat budget is spent. Each phase ends on a closed image.
    task automatic run_phase(input bit [6:0] length_val, input int budget,
                             input bit short_images, input bit hold_output);
        int eff;
        int stop_at;
        int k;
        write_pattern_length(length_val);
        if (hold_output)
            hold_off_req = 1'b1;
        eff     = tracker.active_length();
        stop_at = beats_sent + budget;
        for (k = 0; k < eff; k++)
            send_beat(OP_LOAD, 6'(k), 8'($urandom), $urandom_range(0, 3) == 0,
                      8'($urandom), 1'($urandom));
        while (beats_sent < stop_at)
            scan_image(eff, short_images);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request so
    // the scanner backs up and stalls its input.
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_m_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_off_req = 1'b0;
                i_m_tready   = 1'b1;
            end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_m_tready = 1'b1;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    // Check every report beat as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_report(o_m_tuser[0], o_m_tdata[OUT_OFFSET_W-1:0]);
    end

    initial begin
        tracker     = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = OP_LOAD;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset length of one.
        send_beat(OP_LOAD, 6'd0, 8'hFF, 1'b0, 8'h00, 1'b0);
        send_beat(OP_LOAD, 6'd63, 8'h00, 1'b1, 8'hFF, 1'b1);  // top entry, inactive
        send_scan(8'h00, 1'b0);
        send_scan(8'h12, 1'b0);
        send_scan(8'hFF, 1'b0);   // found at offset 2
        send_scan(8'h00, 1'b0);   // ignored after the hit
        send_scan(8'hFF, 1'b1);   // closes the image without a report
        send_scan(8'h00, 1'b1);   // one-byte image, not found
        send_scan(8'hFF, 1'b1);   // hit on the final byte: found only
        send_beat(OP_LOAD, 6'd0, 8'h00, 1'b1, 8'h00, 1'b0);   // wildcard entry
        send_scan(8'h5A, 1'b0);   // any byte matches at offset 0
        send_scan(8'hA5, 1'b1);

        // Random phases: zero and overlarge lengths, full ring, short images.
        run_phase(7'd1,   90,  1'b0, 1'b0);
        run_phase(7'd0,   80,  1'b0, 1'b0);
        run_phase(7'd2,   100, 1'b0, 1'b0);
        run_phase(7'd64,  200, 1'b0, 1'b0);
        run_phase(7'd127, 150, 1'b0, 1'b0);
        run_phase(7'd5,   100, 1'b0, 1'b0);
        run_phase(7'd1,   80,  1'b1, 1'b1);
        run_phase(7'd3,   100, 1'b0, 1'b0);
        run_phase(7'd12,  100, 1'b0, 1'b0);
        run_phase(7'd33,  100, 1'b0, 1'b0);
        // Last stretch runs at full rate on both sides.
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        run_phase(7'd2,   80,  1'b0, 1'b0);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        repeat (20000) begin
            if (tracker.pending() == 0)
                break;
            @(posedge i_clk);
        end
        if (tracker.pending() != 0) begin
            $display("%0t: %0d reports never arrived", $time, tracker.pending());
            tracker.errors++;
        end
        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
